>>> rtl/core/tilt_pkg.sv
// Shared constants, types and the arctangent table for the tilt-angle core.
package tilt_pkg;

    localparam int SAMPLE_W  = 16;             // raw axis sample width
    localparam int ANGLE_W   = 17;             // output angle width, 1/256 degree
    localparam int PRE_SHIFT = 30;             // fraction bits added to the vector
    localparam int XW        = SAMPLE_W + 2 + PRE_SHIFT;  // vector component width
    localparam int ACC_W     = 25;             // angle accumulator, 2^-16 degree
    localparam int TAB_LEN   = 24;             // entries in the arctangent table
    localparam int TAB_IDX_W = 5;
    localparam int TAB_W     = 24;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT   = 17'sd46080;  // 180 degrees
    localparam logic signed [ANGLE_W-1:0] ANGLE_QUARTER = 17'sd23040;  // 90 degrees
    localparam logic signed [ACC_W-1:0]   ACC_QUARTER   = 25'sd5898240;
    localparam logic        [ACC_W-1:0]   ACC_HALF_LSB  = 25'd128;

    // Early-resolved atan2 result (zero operand cases)
    typedef struct packed {
        logic                       hit;
        logic signed [ANGLE_W-1:0]  val;
    } tilt_spec_t;

    // atan(2^-i) in degrees times 65536, rounded to nearest
    function automatic logic [TAB_W-1:0] atan_tab(input logic [TAB_IDX_W-1:0] idx);
        logic [TAB_W-1:0] r;
        case (idx)
            5'd0:    r = 24'd2949120;
            5'd1:    r = 24'd1740967;
            5'd2:    r = 24'd919879;
            5'd3:    r = 24'd466945;
            5'd4:    r = 24'd234379;
            5'd5:    r = 24'd117304;
            5'd6:    r = 24'd58666;
            5'd7:    r = 24'd29335;
            5'd8:    r = 24'd14668;
            5'd9:    r = 24'd7334;
            5'd10:   r = 24'd3667;
            5'd11:   r = 24'd1833;
            5'd12:   r = 24'd917;
            5'd13:   r = 24'd458;
            5'd14:   r = 24'd229;
            5'd15:   r = 24'd115;
            5'd16:   r = 24'd57;
            5'd17:   r = 24'd29;
            5'd18:   r = 24'd14;
            5'd19:   r = 24'd7;
            5'd20:   r = 24'd4;
            5'd21:   r = 24'd2;
            5'd22:   r = 24'd1;
            default: r = 24'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/tilt_atan2.sv
// Pipelined CORDIC atan2(num, den) in units of 1/256 degree, one stage per round.
module tilt_atan2 import tilt_pkg::*; #(
    parameter int ITERATIONS = 16
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [SAMPLE_W-1:0]  num,
    input  logic signed [SAMPLE_W-1:0]  den,
    output logic signed [ANGLE_W-1:0]   angle
);

    localparam int ROUNDS = (ITERATIONS > TAB_LEN) ? TAB_LEN : ITERATIONS;

    logic signed [XW-1:0]    x_reg   [0:ROUNDS];
    logic signed [XW-1:0]    y_reg   [0:ROUNDS];
    logic signed [ACC_W-1:0] acc_reg [0:ROUNDS];
    tilt_spec_t              sp_reg  [0:ROUNDS+1];

    logic [ANGLE_W-1:0]        rnd_reg;
    logic                      neg_reg;
    logic signed [ANGLE_W-1:0] angle_reg;

    // ---- pre-rotation into the right half plane, zero-operand detect
    logic signed [SAMPLE_W:0]  num_w, den_w, px, py;
    logic signed [ACC_W-1:0]   pacc;
    tilt_spec_t                pspec;

    always_comb begin
        num_w = {num[SAMPLE_W-1], num};
        den_w = {den[SAMPLE_W-1], den};
        if (den_w < 0) begin
            if (num_w >= 0) begin
                px   = num_w;
                py   = -den_w;
                pacc = ACC_QUARTER;
            end else begin
                px   = -num_w;
                py   = den_w;
                pacc = -ACC_QUARTER;
            end
        end else begin
            px   = den_w;
            py   = num_w;
            pacc = '0;
        end

        if (num_w == 0) begin
            pspec.hit = 1'b1;
            pspec.val = (den_w < 0) ? ANGLE_LIMIT : '0;
        end else if (den_w == 0) begin
            pspec.hit = 1'b1;
            pspec.val = (num_w > 0) ? ANGLE_QUARTER : -ANGLE_QUARTER;
        end else begin
            pspec.hit = 1'b0;
            pspec.val = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= {px[SAMPLE_W], px, {PRE_SHIFT{1'b0}}};
            y_reg[0]   <= {py[SAMPLE_W], py, {PRE_SHIFT{1'b0}}};
            acc_reg[0] <= pacc;
            sp_reg[0]  <= pspec;
        end
    end

    // ---- one micro-rotation per stage; shifts floor toward minus infinity
    for (genvar i = 0; i < ROUNDS; i++) begin : g_round
        logic signed [XW-1:0]    xs, ys;
        logic signed [ACC_W-1:0] step;

        assign xs   = x_reg[i] >>> i;
        assign ys   = y_reg[i] >>> i;
        assign step = signed'({1'b0, atan_tab(TAB_IDX_W'(i))});

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1]   <= x_reg[i] + ys;
                    y_reg[i+1]   <= y_reg[i] - xs;
                    acc_reg[i+1] <= acc_reg[i] + step;
                end else begin
                    x_reg[i+1]   <= x_reg[i] - ys;
                    y_reg[i+1]   <= y_reg[i] + xs;
                    acc_reg[i+1] <= acc_reg[i] - step;
                end
                sp_reg[i+1] <= sp_reg[i];
            end
        end
    end

    // ---- round magnitude to 1/256 degree, halves away from zero
    logic [ACC_W-1:0] mag, rsum;

    always_comb begin
        mag  = acc_reg[ROUNDS][ACC_W-1] ? ACC_W'(-acc_reg[ROUNDS]) : ACC_W'(acc_reg[ROUNDS]);
        rsum = mag + ACC_HALF_LSB;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rnd_reg         <= rsum[ACC_W-1:8];
            neg_reg         <= acc_reg[ROUNDS][ACC_W-1];
            sp_reg[ROUNDS+1] <= sp_reg[ROUNDS];
        end
    end

    // ---- clamp, restore sign, pick early result
    logic signed [ANGLE_W-1:0] sat;

    always_comb begin
        sat = (rnd_reg > ANGLE_W'(ANGLE_LIMIT)) ? ANGLE_LIMIT : signed'(rnd_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sp_reg[ROUNDS+1].hit) begin
                angle_reg <= sp_reg[ROUNDS+1].val;
            end else begin
                angle_reg <= neg_reg ? -sat : sat;
            end
        end
    end

    assign angle = angle_reg;

endmodule

>>> rtl/core/accel_tilt_pitch_roll_core.sv
// Top level: pitch and roll angles from one raw three-axis accelerometer item.
//
//  channel  dir  payload (low bit first)                          accepted when
//  s_       in   accel_x[15:0], accel_y[31:16], accel_z[47:32]    s_tvalid & s_tready
//  m_       out  pitch_angle[16:0], roll_angle[33:17], 0 pad      m_tvalid & m_tready
//
// One item enters per cycle while the m_ side is not stalled. Registered steps, ITERATIONS capped at 24:
// pre-rotation, one CORDIC stage per round, rounding, clamp, output register.
// The two atan2 pipelines run side by side and share the valid chain below.
// A stall on the m_ side freezes every stage at once, so items hold in place.
// aresetn (sync, active low) clears the valid bits only; datapath is unreset.
module accel_tilt_pitch_roll_core import tilt_pkg::*; #(
    parameter int ITERATIONS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // pitch_angle[16:0], roll_angle[33:17], zeros[39:34]
);

    localparam int ROUNDS = (ITERATIONS > TAB_LEN) ? TAB_LEN : ITERATIONS;
    localparam int DEPTH  = ROUNDS + 3;    // register stages inside tilt_atan2

    logic                       adv;       // whole pipeline steps
    logic [DEPTH-1:0]           vld_reg, vld_next;
    logic                       m_valid_reg;
    logic signed [ANGLE_W-1:0]  pitch_reg, roll_reg;
    logic signed [ANGLE_W-1:0]  angle_p, angle_r;
    logic signed [SAMPLE_W-1:0] ax, ay, az;

    // Output slot empty or being drained -> everything moves one stage.
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    assign ax = s_tdata[15:0];
    assign ay = s_tdata[31:16];
    assign az = s_tdata[47:32];

    // pitch = -atan2(x, z), roll = atan2(y, z)
    tilt_atan2 #(.ITERATIONS(ITERATIONS)) u_pitch (
        .aclk  (aclk),
        .en    (adv),
        .num   (ax),
        .den   (az),
        .angle (angle_p)
    );

    tilt_atan2 #(.ITERATIONS(ITERATIONS)) u_roll (
        .aclk  (aclk),
        .en    (adv),
        .num   (ay),
        .den   (az),
        .angle (angle_r)
    );

    // Valid bits ride alongside the datapath stages.
    always_comb begin
        vld_next = {vld_reg[DEPTH-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= vld_next;
            m_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    // Output register; angles are within +/-180 deg so the negate cannot wrap.
    always_ff @(posedge aclk) begin
        if (adv) begin
            pitch_reg <= -angle_p;
            roll_reg  <= angle_r;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, roll_reg, pitch_reg};

    // ---- checks
    logic signed [ANGLE_W-1:0] chk_pitch, chk_roll;
    assign chk_pitch = m_tdata[16:0];
    assign chk_roll  = m_tdata[33:17];

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (chk_pitch <= ANGLE_LIMIT) && (chk_pitch >= -ANGLE_LIMIT))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (chk_roll <= ANGLE_LIMIT) && (chk_roll >= -ANGLE_LIMIT))
        else $error("roll out of range");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_tail_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[DEPTH-1] && s_tready) |=> m_tvalid)
        else $error("item lost at output register");

    a_stall_freezes_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("valid chain moved during stall");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the accelerometer pitch/roll angle core.
module testbench;
    import tilt_pkg::*;

    localparam int     ROUNDS        = 16;             // CORDIC rounds of the instance
    localparam int     DRAIN_CYCLES  = ROUNDS + 4 + 16;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     RANDOM_ITEMS  = 260;            // per handshake phase
    localparam int     DIRECTED_ROWS = 22;
    localparam longint DEG180_Q8     = 46080;          // 180 degrees, 1/256 degree units
    localparam longint DEG90_Q8      = 23040;
    localparam longint DEG90_Q16     = 90 * 65536;     // accumulator units, 2^-16 degree

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
    } tilt_angles_t;

    // One directed sample; angles are typed in only where they are obvious
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ax;
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] az;
        bit                         typed;
        logic signed [ANGLE_W-1:0]  pitch;
        logic signed [ANGLE_W-1:0]  roll;
    } tilt_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // pitch_angle[16:0], roll_angle[33:17], zeros[39:34]

    tilt_angles_t pending_angles[$];
    int           src_idle_pct  = 24;
    int           dst_stall_pct = 63;
    int           error_count   = 0;
    int           items_sent    = 0;
    int           angles_seen   = 0;
    int           cycle_count   = 0;

    // atan(2^-i) in degrees times 65536
    longint arctan_steps [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    tilt_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{0, 0, 0, 1'b1, 0, 0},                     // both operands zero
        '{0, 0, 32767, 1'b1, 0, 0},                 // zero numerator, positive z
        '{0, 0, -32768, 1'b1, -46080, 46080},       // zero numerator, negative z: 180
        '{0, 0, -1, 1'b1, -46080, 46080},
        '{1, -1, 0, 1'b1, -23040, -23040},          // z zero: exact quarter turns
        '{-32768, 32767, 0, 1'b1, 23040, 23040},
        '{32767, 32767, 32767, 1'b0, 0, 0},
        '{-32768, -32768, -32768, 1'b0, 0, 0},
        '{32767, -32768, -32768, 1'b0, 0, 0},
        '{-32768, 32767, -32768, 1'b0, 0, 0},
        '{1, -1, -32768, 1'b0, 0, 0},               // just off 180, clamp region
        '{-1, 1, -32768, 1'b0, 0, 0},
        '{1, 1, 1, 1'b0, 0, 0},
        '{-1, -1, -1, 1'b0, 0, 0},
        '{-32768, -32768, 1, 1'b0, 0, 0},
        '{32767, 32767, -1, 1'b0, 0, 0},
        '{16384, -16384, 16384, 1'b0, 0, 0},
        '{0, 12345, -12345, 1'b0, 0, 0},
        '{-21000, 0, 21000, 1'b0, 0, 0},
        '{21845, -21846, 10922, 1'b0, 0, 0},
        '{-1, -1, 32767, 1'b0, 0, 0},
        '{0, -7, -3, 1'b0, 0, 0}
    };

    accel_tilt_pitch_roll_core #(.ITERATIONS(ROUNDS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // atan2(num, den) in 1/256 degree: zero operands return at once; else pre-rotate into the
    // right half plane, run vectoring CORDIC with floor shifts, round halves away from zero, clamp.
    function automatic longint atan2_q8(longint num, longint den);
        longint vx, vy, sx, sy, tmp, acc, mag;
        int     i;
        if (num == 0)
            return (den < 0) ? DEG180_Q8 : 0;
        if (den == 0)
            return (num > 0) ? DEG90_Q8 : -DEG90_Q8;
        vx  = den <<< 30;
        vy  = num <<< 30;
        acc = 0;
        if (vx < 0) begin
            tmp = vx;
            if (vy >= 0) begin
                vx  = vy;
                vy  = -tmp;
                acc = DEG90_Q16;
            end else begin
                vx  = -vy;
                vy  = tmp;
                acc = -DEG90_Q16;
            end
        end
        for (i = 0; i < ROUNDS && i < 24; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy > 0) begin
                vx  = vx + sy;
                vy  = vy - sx;
                acc = acc + arctan_steps[i];
            end else begin
                vx  = vx - sy;
                vy  = vy + sx;
                acc = acc - arctan_steps[i];
            end
        end
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + 128) >>> 8;
        mag = (acc < 0) ? -mag : mag;
        if (mag > DEG180_Q8)
            mag = DEG180_Q8;
        if (mag < -DEG180_Q8)
            mag = -DEG180_Q8;
        return mag;
    endfunction

    function automatic tilt_angles_t predict_angles(logic signed [SAMPLE_W-1:0] ax,
                                                    logic signed [SAMPLE_W-1:0] ay,
                                                    logic signed [SAMPLE_W-1:0] az);
        tilt_angles_t a;
        longint       p, r;
        p       = -atan2_q8(longint'(ax), longint'(az));
        r       = atan2_q8(longint'(ay), longint'(az));
        a.pitch = p[ANGLE_W-1:0];
        a.roll  = r[ANGLE_W-1:0];
        return a;
    endfunction

    // Axis value of a given flavor: full range, near zero, zero, edge codes, mid range
    function automatic logic signed [SAMPLE_W-1:0] pick_axis(int unsigned flavor);
        case (flavor)
            1: return 16'($urandom_range(8)) - 16'd4;
            2: return '0;
            3: begin
                case ($urandom_range(5))
                    0: return 16'h8000;
                    1: return 16'h8001;
                    2: return 16'hFFFF;
                    3: return 16'h0000;
                    4: return 16'h0001;
                    default: return 16'h7FFF;
                endcase
            end
            4: return 16'($urandom_range(600)) - 16'd300;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Offer one sample, with random idle cycles first; queue its angles on acceptance
    task automatic send_sample(logic signed [SAMPLE_W-1:0] ax,
                               logic signed [SAMPLE_W-1:0] ay,
                               logic signed [SAMPLE_W-1:0] az,
                               bit typed,
                               logic signed [ANGLE_W-1:0] tp,
                               logic signed [ANGLE_W-1:0] tr);
        tilt_angles_t want;
        if (typed) begin
            want.pitch = tp;
            want.roll  = tr;
        end else begin
            want = predict_angles(ax, ay, az);
        end
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        do @(posedge aclk); while (!s_tready);
        pending_angles.push_back(want);
        items_sent++;
    endtask

    task automatic check_angles(logic [39:0] word);
        tilt_angles_t want;
        angles_seen++;
        if (pending_angles.size() == 0) begin
            report_mismatch("result with nothing pending, pitch", $signed(word[16:0]), 0);
            return;
        end
        want = pending_angles.pop_front();
        if (word[16:0] != want.pitch)
            report_mismatch("pitch_angle", $signed(word[16:0]), want.pitch);
        if (word[33:17] != want.roll)
            report_mismatch("roll_angle", $signed(word[33:17]), want.roll);
        if (word[39:34] != '0)
            report_mismatch("pad bits", word[39:34], 0);
    endtask

    // Receiver: random back-pressure, check every accepted result
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= dst_stall_pct);
        if (aresetn && m_tvalid && m_tready)
            check_angles(m_tdata);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d results pending", pending_angles.size());
            $display("accel_tilt_pitch_roll_core test failed");
            $finish;
        end
    end

    initial begin
        int                         phase, n;
        logic signed [SAMPLE_W-1:0] ax, ay, az;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k])
            send_sample(directed_rows[k].ax, directed_rows[k].ay, directed_rows[k].az,
                        directed_rows[k].typed, directed_rows[k].pitch,
                        directed_rows[k].roll);

        // hold off until the pipeline has fully drained
        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge aclk);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 24; dst_stall_pct = 63; end
                1: begin src_idle_pct = 63; dst_stall_pct = 24; end
                default: begin src_idle_pct = 0; dst_stall_pct = 0; end
            endcase
            for (n = 0; n < RANDOM_ITEMS; n++) begin
                // mostly full-range axes, the rest near zero, zero, edges, mid range
                ax = pick_axis(($urandom_range(9) < 6) ? 0 : $urandom_range(1, 4));
                ay = pick_axis(($urandom_range(9) < 6) ? 0 : $urandom_range(1, 4));
                az = pick_axis(($urandom_range(9) < 6) ? 0 : $urandom_range(1, 4));
                send_sample(ax, ay, az, 1'b0, '0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d directed and %0d random samples under three handshake mixes",
                 DIRECTED_ROWS, items_sent - DIRECTED_ROWS);
        $display("checked %0d pitch/roll results, %0d mismatches", angles_seen, error_count);
        if (error_count == 0)
            $display("accel_tilt_pitch_roll_core test passed");
        else
            $display("accel_tilt_pitch_roll_core test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/tilt_pkg.sv
rtl/core/tilt_atan2.sv
rtl/core/accel_tilt_pitch_roll_core.sv
sim/testbench.sv
